// ===== sv/soctl_pkg.sv =====
// Shared types, widths and helpers for the sparse octree build and lookup block.
// No dependencies; soctl_shift and the top-level file import this package.
`default_nettype none

package soctl_pkg;

  localparam int MAX_LEVELS = 6;
  localparam int NODES      = 1024;
  localparam int LVL_W      = 3;
  localparam int IDX_W      = 10;
  localparam int FILL_W     = 11;
  localparam int CODE_W     = 18;
  localparam int CNT_W      = 16;
  localparam int SITES_W    = 32;
  localparam int LINK_W     = 11;
  localparam int SHAMT_W    = 5;
  localparam int NODE_AW    = LVL_W + IDX_W;
  localparam int LINK_AW    = LVL_W + IDX_W + 3;
  localparam int NODE_DEPTH = (MAX_LEVELS + 1) * NODES;
  localparam int LINK_DEPTH = MAX_LEVELS * NODES * 8;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_FULL         = 3'd2,
    ST_ORDER        = 3'd3,
    ST_INCONSISTENT = 3'd4,
    ST_SKIPPED      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_INS_UPD,
    S_INS_MRG,
    S_INS_LINK,
    S_LK_RD,
    S_LK_CHK,
    S_LK_LNK
  } fsm_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // Effective number of levels: the register value clamped to 1..MAX_LEVELS.
  function automatic logic [LVL_W-1:0] lc_eff(input logic [LVL_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = v;
    if (v == '0) r = LVL_W'(1);
    if (v > LVL_W'(MAX_LEVELS)) r = LVL_W'(MAX_LEVELS);
    return r;
  endfunction

  // Three code bits per level: shift amount for a level difference.
  function automatic logic [SHAMT_W-1:0] times3(input logic [LVL_W-1:0] d);
    return {{(SHAMT_W-LVL_W){1'b0}}, d} + {{(SHAMT_W-LVL_W-1){1'b0}}, d, 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== sv/soctl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module soctl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/soctl_shift.sv =====
// Shared code shifter: the node code of a path at a given level and the child digit below it.
// Depends on soctl_pkg.
`default_nettype none

module soctl_shift (
  input  wire logic [soctl_pkg::CODE_W-1:0] code,
  input  wire logic [soctl_pkg::LVL_W-1:0]  lc,
  input  wire logic [soctl_pkg::LVL_W-1:0]  lvl,
  output logic      [soctl_pkg::CODE_W-1:0] pc,
  output logic      [2:0]                   loc_next
);
  import soctl_pkg::*;

  logic [LVL_W-1:0]   diff;
  logic [SHAMT_W-1:0] amt;
  logic [CODE_W-1:0]  below;

  assign diff = lc - lvl;
  assign amt  = times3(diff);
  assign pc   = code >> amt;

  // The digit that selects the child is the next three bits under this level.
  always_comb begin
    below = '0;
    if (diff != '0) begin
      below = code >> (amt - SHAMT_W'(3));
    end
  end
  assign loc_next = below[2:0];

endmodule

`default_nettype wire

// ===== sv/sparse_octree_build_and_lookup.sv =====
// Sparse octree build and lookup, one item at a time under a small sequencer.
// Insert (L levels): a read and check per level, then a write at the leaf and, per parent, eight link
// writes through the single link memory port when created or a sites merge and one link write when
// merged. Lookup: read, check and link per level above the leaf, read and check at the leaf; errors
// end early. The result strobe follows in the cycle after the last step; busy is low from that cycle.
// Synchronous active-low reset empties all levels and sets level_count to 6; the receiver cannot stall.
`default_nettype none

module sparse_octree_build_and_lookup (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_op,
  input  wire logic [soctl_pkg::CODE_W-1:0]    in_oct_code,
  input  wire logic [soctl_pkg::CNT_W-1:0]     in_site_count,
  output logic                                 out_strobe,
  output logic      [2:0]                      out_status,
  output logic                                 out_leaf_found,
  output logic      [soctl_pkg::IDX_W-1:0]     out_leaf_index,
  output logic      [soctl_pkg::LVL_W-1:0]     out_deepest_level,
  output logic      [soctl_pkg::IDX_W-1:0]     out_node_index,
  output logic      [soctl_pkg::SITES_W-1:0]   out_node_sites,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [soctl_pkg::LVL_W-1:0]     cfg_level_count
);
  import soctl_pkg::*;

  fsm_t                state_r, state_nxt;
  logic [LVL_W-1:0]    level_count_r;
  logic [FILL_W-1:0]   fill_r [0:MAX_LEVELS];
  logic                fill_inc;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [MAX_LEVELS:0] fresh_r, fresh_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [IDX_W-1:0]    cidx_r, cidx_nxt;
  logic [2:0]          cloc_r, cloc_nxt;
  logic [IDX_W-1:0]    leaf_r, leaf_nxt;
  logic [CODE_W-1:0]   code_r, code_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LVL_W-1:0]    okl_r, okl_nxt;
  logic [IDX_W-1:0]    oki_r, oki_nxt;
  logic [SITES_W-1:0]  oks_r, oks_nxt;

  logic                out_strobe_r;
  status_t             out_status_r, fin_st;
  logic                out_found_r, fin_found;
  logic [IDX_W-1:0]    out_leaf_r, fin_leaf;
  logic [LVL_W-1:0]    out_lvl_r, fin_lvl;
  logic [IDX_W-1:0]    out_node_r, fin_node;
  logic [SITES_W-1:0]  out_sites_r, fin_sites;
  logic                fin;

  logic [LVL_W-1:0]    lc;
  logic [CODE_W-1:0]   code_mask;
  logic [FILL_W-1:0]   fill_cur;
  logic [FILL_W-1:0]   fill_m1;
  logic [CODE_W-1:0]   pc;
  logic [2:0]          loc_next;
  logic [SITES_W:0]    sum_wide;
  logic [SITES_W-1:0]  sum_sat;
  logic [LINK_W-1:0]   link_val;
  logic                link_last;
  logic                has_node;
  logic                is_new;

  logic                code_we, sites_we, link_we;
  logic [NODE_AW-1:0]  code_waddr, code_raddr, sites_waddr, sites_raddr;
  logic [LINK_AW-1:0]  link_waddr, link_raddr;
  logic [CODE_W-1:0]   code_wdata, code_rd;
  logic [SITES_W-1:0]  sites_wdata, sites_rd;
  logic [LINK_W-1:0]   link_wdata, link_rd;

  assign lc        = lc_eff(level_count_r);
  assign code_mask = ~({CODE_W{1'b1}} << times3(lc));
  assign fill_cur  = fill_r[lvl_r];
  assign fill_m1   = fill_cur - FILL_W'(1);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = ~busy;
  assign sum_wide  = {1'b0, sites_rd} + {{(SITES_W-CNT_W+1){1'b0}}, cnt_r};
  assign sum_sat   = sum_wide[SITES_W] ? {SITES_W{1'b1}} : sum_wide[SITES_W-1:0];
  assign link_val  = {1'b0, cidx_r} + LINK_W'(1);
  assign has_node  = (fill_cur != '0);

  soctl_shift u_shift (
    .code     (code_r),
    .lc       (lc),
    .lvl      (lvl_r),
    .pc       (pc),
    .loc_next (loc_next)
  );

  soctl_ram #(.WIDTH(CODE_W), .DEPTH(NODE_DEPTH)) u_code_ram (
    .clk(clk), .we(code_we), .waddr(code_waddr), .wdata(code_wdata),
    .raddr(code_raddr), .rdata(code_rd)
  );

  soctl_ram #(.WIDTH(SITES_W), .DEPTH(NODE_DEPTH)) u_sites_ram (
    .clk(clk), .we(sites_we), .waddr(sites_waddr), .wdata(sites_wdata),
    .raddr(sites_raddr), .rdata(sites_rd)
  );

  soctl_ram #(.WIDTH(LINK_W), .DEPTH(LINK_DEPTH)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      level_count_r <= LVL_W'(MAX_LEVELS);
      out_strobe_r  <= 1'b0;
      for (int i = 0; i <= MAX_LEVELS; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= fin;
      if (cfg_valid && cfg_ready) begin
        level_count_r <= cfg_level_count;
      end
      if (fill_inc) begin
        fill_r[lvl_r] <= fill_cur + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    idx_r   <= idx_nxt;
    fresh_r <= fresh_nxt;
    k_r     <= k_nxt;
    cidx_r  <= cidx_nxt;
    cloc_r  <= cloc_nxt;
    leaf_r  <= leaf_nxt;
    code_r  <= code_nxt;
    cnt_r   <= cnt_nxt;
    okl_r   <= okl_nxt;
    oki_r   <= oki_nxt;
    oks_r   <= oks_nxt;
    if (fin) begin
      out_status_r <= fin_st;
      out_found_r  <= fin_found;
      out_leaf_r   <= fin_leaf;
      out_lvl_r    <= fin_lvl;
      out_node_r   <= fin_node;
      out_sites_r  <= fin_sites;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    lvl_nxt     = lvl_r;
    idx_nxt     = idx_r;
    fresh_nxt   = fresh_r;
    k_nxt       = k_r;
    cidx_nxt    = cidx_r;
    cloc_nxt    = cloc_r;
    leaf_nxt    = leaf_r;
    code_nxt    = code_r;
    cnt_nxt     = cnt_r;
    okl_nxt     = okl_r;
    oki_nxt     = oki_r;
    oks_nxt     = oks_r;
    fill_inc    = 1'b0;
    fin         = 1'b0;
    fin_st      = ST_OK;
    fin_found   = 1'b0;
    fin_leaf    = '0;
    fin_lvl     = '0;
    fin_node    = '0;
    fin_sites   = '0;
    is_new      = 1'b0;
    link_last   = 1'b0;
    code_we     = 1'b0;
    code_waddr  = {lvl_r, idx_r};
    code_wdata  = pc;
    code_raddr  = {lvl_r, idx_r};
    sites_we    = 1'b0;
    sites_waddr = {lvl_r, idx_r};
    sites_wdata = {{(SITES_W-CNT_W){1'b0}}, cnt_r};
    sites_raddr = {lvl_r, idx_r};
    link_we     = 1'b0;
    link_waddr  = {lvl_r, idx_r, k_r};
    link_wdata  = '0;
    link_raddr  = {lvl_r, idx_r, loc_next};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          code_nxt = in_oct_code & code_mask;
          cnt_nxt  = in_site_count;
          if (op_t'(in_op) == OP_INSERT) begin
            if (in_site_count == '0) begin
              fin    = 1'b1;
              fin_st = ST_SKIPPED;
            end else begin
              lvl_nxt   = lc;
              state_nxt = S_INS_RD;
            end
          end else if (fill_r[0] == '0) begin
            fin    = 1'b1;
            fin_st = ST_NOT_FOUND;
          end else begin
            lvl_nxt   = '0;
            idx_nxt   = '0;
            okl_nxt   = '0;
            oki_nxt   = '0;
            oks_nxt   = '0;
            state_nxt = S_LK_RD;
          end
        end
      end

      // Fetch the last node of the level; its code decides order, merge or create.
      S_INS_RD: begin
        code_raddr = {lvl_r, fill_m1[IDX_W-1:0]};
        state_nxt  = S_INS_CHK;
      end

      S_INS_CHK: begin
        if (lvl_r == lc) begin
          if (has_node && (code_r <= code_rd)) begin
            fin       = 1'b1;
            fin_st    = ST_ORDER;
            state_nxt = S_IDLE;
          end else if (fill_cur[IDX_W]) begin
            fin       = 1'b1;
            fin_st    = ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            fresh_nxt[lvl_r] = 1'b1;
            lvl_nxt          = '0;
            state_nxt        = S_INS_RD;
          end
        end else begin
          is_new = !has_node || (code_rd != pc);
          if (is_new && fill_cur[IDX_W]) begin
            fin       = 1'b1;
            fin_st    = ST_FULL;
            state_nxt = S_IDLE;
          end else begin
            fresh_nxt[lvl_r] = is_new;
            if (lvl_r == lc - LVL_W'(1)) begin
              lvl_nxt   = lc;
              state_nxt = S_INS_UPD;
            end else begin
              lvl_nxt   = lvl_r + LVL_W'(1);
              state_nxt = S_INS_RD;
            end
          end
        end
      end

      S_INS_UPD: begin
        if (fresh_r[lvl_r]) begin
          code_we     = 1'b1;
          code_waddr  = {lvl_r, fill_cur[IDX_W-1:0]};
          sites_we    = 1'b1;
          sites_waddr = {lvl_r, fill_cur[IDX_W-1:0]};
          fill_inc    = 1'b1;
          idx_nxt     = fill_cur[IDX_W-1:0];
          if (lvl_r == lc) begin
            leaf_nxt = fill_cur[IDX_W-1:0];
            cidx_nxt = fill_cur[IDX_W-1:0];
            cloc_nxt = pc[2:0];
            lvl_nxt  = lvl_r - LVL_W'(1);
          end else begin
            k_nxt     = '0;
            state_nxt = S_INS_LINK;
          end
        end else begin
          sites_raddr = {lvl_r, fill_m1[IDX_W-1:0]};
          idx_nxt     = fill_m1[IDX_W-1:0];
          state_nxt   = S_INS_MRG;
        end
      end

      S_INS_MRG: begin
        sites_we    = 1'b1;
        sites_wdata = sum_sat;
        state_nxt   = S_INS_LINK;
      end

      // A new parent gets all eight links written, only the child's one nonzero.
      S_INS_LINK: begin
        link_we = 1'b1;
        if (fresh_r[lvl_r]) begin
          link_wdata = (k_r == cloc_r) ? link_val : '0;
          k_nxt      = k_r + 3'd1;
          link_last  = (k_r == 3'd7);
        end else begin
          link_waddr = {lvl_r, idx_r, cloc_r};
          link_wdata = link_val;
          link_last  = 1'b1;
        end
        if (link_last) begin
          cidx_nxt = idx_r;
          cloc_nxt = pc[2:0];
          if (lvl_r == '0) begin
            fin       = 1'b1;
            fin_st    = ST_OK;
            fin_leaf  = leaf_r;
            fin_lvl   = lc;
            fin_node  = leaf_r;
            fin_sites = {{(SITES_W-CNT_W){1'b0}}, cnt_r};
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt   = lvl_r - LVL_W'(1);
            state_nxt = S_INS_UPD;
          end
        end
      end

      S_LK_RD: begin
        if ({1'b0, idx_r} >= fill_cur) begin
          fin       = 1'b1;
          fin_st    = ST_INCONSISTENT;
          fin_lvl   = okl_r;
          fin_node  = oki_r;
          fin_sites = oks_r;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LK_CHK;
        end
      end

      S_LK_CHK: begin
        if (code_rd != pc) begin
          fin       = 1'b1;
          fin_st    = ST_INCONSISTENT;
          fin_lvl   = okl_r;
          fin_node  = oki_r;
          fin_sites = oks_r;
          state_nxt = S_IDLE;
        end else begin
          okl_nxt = lvl_r;
          oki_nxt = idx_r;
          oks_nxt = sites_rd;
          if (lvl_r == lc) begin
            fin       = 1'b1;
            fin_st    = ST_OK;
            fin_found = 1'b1;
            fin_leaf  = idx_r;
            fin_lvl   = lc;
            fin_node  = idx_r;
            fin_sites = sites_rd;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LK_LNK;
          end
        end
      end

      S_LK_LNK: begin
        if (link_rd == '0) begin
          fin       = 1'b1;
          fin_st    = ST_NOT_FOUND;
          fin_lvl   = okl_r;
          fin_node  = oki_r;
          fin_sites = oks_r;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = link_rd[IDX_W-1:0] - IDX_W'(1);
          lvl_nxt   = lvl_r + LVL_W'(1);
          state_nxt = S_LK_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_leaf_found    = out_found_r;
  assign out_leaf_index    = out_leaf_r;
  assign out_deepest_level = out_lvl_r;
  assign out_node_index    = out_node_r;
  assign out_node_sites    = out_sites_r;

`ifndef SYNTHESIS
  // An accepted word either starts the sequencer or is answered on the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_strobe)
    else $error("accepted word neither started nor answered");

  // A result is only presented once the sequencer is back to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // The root level never holds more nodes than its table.
  a_root_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FILL_W'(NODES))
    else $error("root level overfilled");

  // The root level holds at most one node.
  a_single_root: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FILL_W'(1))
    else $error("more than one root node");
`endif

endmodule

`default_nettype wire
